// ===== src/rpcv_pkg.sv =====
`default_nettype none
package rpcv_pkg;

    localparam int MAX_DIM     = 512;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 9;
    localparam int SIZE_W      = 10;
    localparam int PIX_W       = 8;
    localparam int CLS_W       = 2;
    localparam int DIR_W       = 3;
    localparam int ODD_W       = 4;
    localparam int STEP_W      = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);
    localparam logic [ODD_W-1:0]  VOTE_MIN   = ODD_W'(4);
    localparam logic [PIX_W-1:0]  PIX_FULL   = PIX_W'(255);
    localparam logic [DIR_W-1:0]  DIR_LAST   = DIR_W'(7);

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 1'b1;

    localparam logic [CLS_W-1:0] CLS_ZERO  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FULL  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CHECK,
        OP_CENTER,
        OP_RAY_INIT,
        OP_STEP,
        OP_CMP,
        OP_RAY_END,
        OP_EMIT_VOTE,
        OP_EMIT_BAD,
        OP_EMIT_IN
    } op_t;

    typedef enum logic [1:0] {
        MV_HOLD,
        MV_INC,
        MV_DEC
    } move_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic query;
        logic bad;
        logic full;
        logic at_edge;
        logic last_dir;
        logic out_busy;
    } stat_t;

    function automatic move_t dir_dx(input logic [DIR_W-1:0] d);
        move_t m;
        unique case (d)
            3'd0, 3'd4, 3'd5: m = MV_INC;
            3'd1, 3'd6, 3'd7: m = MV_DEC;
            default:          m = MV_HOLD;
        endcase
        return m;
    endfunction

    function automatic move_t dir_dy(input logic [DIR_W-1:0] d);
        move_t m;
        unique case (d)
            3'd2, 3'd4, 3'd6: m = MV_INC;
            3'd3, 3'd5, 3'd7: m = MV_DEC;
            default:          m = MV_HOLD;
        endcase
        return m;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (int'(s) > MAX_DIM)
            r = SIZE_W'(MAX_DIM);
        else
            r = s;
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] pix_class(input logic [PIX_W-1:0] p);
        logic [CLS_W-1:0] c;
        if (p == '0)
            c = CLS_ZERO;
        else if (p == PIX_FULL)
            c = CLS_FULL;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        return ADDR_W'(x) * ADDR_W'(MAX_DIM) + ADDR_W'(y);
    endfunction

endpackage
`default_nettype wire

// ===== src/rpcv_in_if.sv =====
`default_nettype none
interface rpcv_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [rpcv_pkg::COORD_W-1:0]   coord_x;
    logic [rpcv_pkg::COORD_W-1:0]   coord_y;
    logic [rpcv_pkg::PIX_W-1:0]     pixel_value;

    modport source (output valid, action, coord_x, coord_y, pixel_value, input ready);
    modport sink   (input valid, action, coord_x, coord_y, pixel_value, output ready);
endinterface
`default_nettype wire

// ===== src/rpcv_out_if.sv =====
`default_nettype none
interface rpcv_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic bad_point;

    modport source (output valid, inside_res, bad_point, input ready);
    modport sink   (input valid, inside_res, bad_point, output ready);
endinterface
`default_nettype wire

// ===== src/raster_point_in_contour_vote_core.sv =====
`default_nettype none
// Point-in-contour test on a stored raster of pixel classes (zero, full, other).
// in_ch carries requests: action 0 writes one pixel at (coord_x, coord_y),
// action 1 queries that point. Writes give no result.
// out_ch returns one result per query: inside_res and bad_point.
// A query outside size_x by size_y answers bad_point; a query on a full pixel
// answers inside without walking a ray. Otherwise eight rays are walked from
// the point, one pixel at a time on the single read port of the store; two
// opposite rays together walk at most 511 pixels on a 512 by 512 image.
// A new request is taken only while the sequencer waits at its idle step; a
// finished result sits in the output register, so the next request can enter
// while it waits. If the receiver stalls a second result, the sequencer holds
// at that result step until the output register drains.
// cfg_we writes size_x (index 0) or size_y (index 1); write only while idle.
// Reset returns both sizes to 512 and empties the output register; the pixel
// store is not cleared and must be written before it is queried.
module raster_point_in_contour_vote_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rpcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rpcv_pkg::SIZE_W-1:0]      cfg_data,
    rpcv_in_if.sink                               in_ch,
    rpcv_out_if.source                            out_ch
);

    rpcv_pkg::ctrl_t ctrl;
    rpcv_pkg::stat_t stat;

    rpcv_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rpcv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

// ===== src/rpcv_ram.sv =====
`default_nettype none
module rpcv_ram (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [rpcv_pkg::ADDR_W-1:0]   waddr,
    input  wire logic [rpcv_pkg::CLS_W-1:0]    wdata,
    input  wire logic [rpcv_pkg::ADDR_W-1:0]   raddr,
    output logic      [rpcv_pkg::CLS_W-1:0]    rdata
);

    logic [rpcv_pkg::CLS_W-1:0] mem [rpcv_pkg::STORE_DEPTH];
    logic [rpcv_pkg::CLS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/rpcv_seq.sv =====
`default_nettype none
module rpcv_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rpcv_pkg::stat_t stat,
    output rpcv_pkg::ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_QUERY,
        CND_BAD,
        CND_FULL,
        CND_EDGE,
        CND_LAST_DIR,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        rpcv_pkg::op_t                  op;
        cond_t                          cond;
        logic [rpcv_pkg::STEP_W-1:0]    seq_to;
        logic [rpcv_pkg::STEP_W-1:0]    jmp_to;
    } uword_t;

    localparam logic [rpcv_pkg::STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_CHECK     = 4'd1;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_CENTER    = 4'd2;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_RAY_INIT  = 4'd3;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_STEP      = 4'd4;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_CMP       = 4'd5;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_RAY_END   = 4'd6;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_EMIT_VOTE = 4'd7;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_EMIT_BAD  = 4'd8;
    localparam logic [rpcv_pkg::STEP_W-1:0] S_EMIT_IN   = 4'd9;

    // Control store: fall through to seq_to, or jump to jmp_to when cond holds.
    function automatic uword_t rom(input logic [rpcv_pkg::STEP_W-1:0] a);
        uword_t w;
        unique case (a)
            S_IDLE:      w = '{rpcv_pkg::OP_IDLE,      CND_QUERY,    S_IDLE,      S_CHECK};
            S_CHECK:     w = '{rpcv_pkg::OP_CHECK,     CND_BAD,      S_CENTER,    S_EMIT_BAD};
            S_CENTER:    w = '{rpcv_pkg::OP_CENTER,    CND_FULL,     S_RAY_INIT,  S_EMIT_IN};
            S_RAY_INIT:  w = '{rpcv_pkg::OP_RAY_INIT,  CND_NEVER,    S_STEP,      S_STEP};
            S_STEP:      w = '{rpcv_pkg::OP_STEP,      CND_EDGE,     S_CMP,       S_RAY_END};
            S_CMP:       w = '{rpcv_pkg::OP_CMP,       CND_NEVER,    S_STEP,      S_STEP};
            S_RAY_END:   w = '{rpcv_pkg::OP_RAY_END,   CND_LAST_DIR, S_RAY_INIT,  S_EMIT_VOTE};
            S_EMIT_VOTE: w = '{rpcv_pkg::OP_EMIT_VOTE, CND_OUT_BUSY, S_IDLE,      S_EMIT_VOTE};
            S_EMIT_BAD:  w = '{rpcv_pkg::OP_EMIT_BAD,  CND_OUT_BUSY, S_IDLE,      S_EMIT_BAD};
            S_EMIT_IN:   w = '{rpcv_pkg::OP_EMIT_IN,   CND_OUT_BUSY, S_IDLE,      S_EMIT_IN};
            default:     w = '{rpcv_pkg::OP_IDLE,      CND_NEVER,    S_IDLE,      S_IDLE};
        endcase
        return w;
    endfunction

    logic [rpcv_pkg::STEP_W-1:0] step_reg;
    logic [rpcv_pkg::STEP_W-1:0] step_next;
    uword_t                      word;
    logic                        take;

    always_comb
    begin
        word = rom(step_reg);
        unique case (word.cond)
            CND_NEVER:    take = 1'b0;
            CND_QUERY:    take = stat.query;
            CND_BAD:      take = stat.bad;
            CND_FULL:     take = stat.full;
            CND_EDGE:     take = stat.at_edge;
            CND_LAST_DIR: take = stat.last_dir;
            CND_OUT_BUSY: take = stat.out_busy;
            default:      take = 1'b0;
        endcase
        step_next = take ? word.jmp_to : word.seq_to;
        ctrl.op   = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rpcv_dp.sv =====
`default_nettype none
module rpcv_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rpcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rpcv_pkg::SIZE_W-1:0]      cfg_data,
    input  wire rpcv_pkg::ctrl_t                  ctrl,
    output rpcv_pkg::stat_t                       stat,
    rpcv_in_if.sink                               in_ch,
    rpcv_out_if.source                            out_ch
);

    localparam int CW = rpcv_pkg::COORD_W;
    localparam int SW = rpcv_pkg::SIZE_W;

    logic [SW-1:0] size_x_reg, size_x_next;
    logic [SW-1:0] size_y_reg, size_y_next;
    logic          out_valid_reg, out_valid_next;
    logic          inside_reg, inside_next;
    logic          bad_reg, bad_next;

    logic [CW-1:0]                  ox_reg, ox_next;
    logic [CW-1:0]                  oy_reg, oy_next;
    logic [CW-1:0]                  px_reg, px_next;
    logic [CW-1:0]                  py_reg, py_next;
    logic [rpcv_pkg::CLS_W-1:0]     ocls_reg, ocls_next;
    logic [rpcv_pkg::CLS_W-1:0]     prev_reg, prev_next;
    logic                           par_reg, par_next;
    logic [rpcv_pkg::DIR_W-1:0]     dir_reg, dir_next;
    logic [rpcv_pkg::ODD_W-1:0]     odd_reg, odd_next;

    logic                           accept;
    logic                           wr_en;
    logic [rpcv_pkg::ADDR_W-1:0]    raddr;
    logic [rpcv_pkg::CLS_W-1:0]     rdata;
    logic [SW-1:0]                  sx, sy;
    logic [CW-1:0]                  nx, ny;
    rpcv_pkg::move_t                mvx, mvy;
    logic                           edge_x, edge_y;
    logic                           emit, out_free;

    assign in_ch.ready = (ctrl.op == rpcv_pkg::OP_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign wr_en       = accept && !in_ch.action
                         && (int'(in_ch.coord_x) < rpcv_pkg::MAX_DIM)
                         && (int'(in_ch.coord_y) < rpcv_pkg::MAX_DIM);

    assign sx  = rpcv_pkg::eff_size(size_x_reg);
    assign sy  = rpcv_pkg::eff_size(size_y_reg);
    assign mvx = rpcv_pkg::dir_dx(dir_reg);
    assign mvy = rpcv_pkg::dir_dy(dir_reg);

    // A ray stops once the next pixel would leave the configured image.
    assign edge_x = ((mvx == rpcv_pkg::MV_INC) && (({1'b0, px_reg} + 1'b1) >= sx))
                    || ((mvx == rpcv_pkg::MV_DEC) && (px_reg == '0));
    assign edge_y = ((mvy == rpcv_pkg::MV_INC) && (({1'b0, py_reg} + 1'b1) >= sy))
                    || ((mvy == rpcv_pkg::MV_DEC) && (py_reg == '0));

    always_comb
    begin
        unique case (mvx)
            rpcv_pkg::MV_INC: nx = px_reg + 1'b1;
            rpcv_pkg::MV_DEC: nx = px_reg - 1'b1;
            default:          nx = px_reg;
        endcase
        unique case (mvy)
            rpcv_pkg::MV_INC: ny = py_reg + 1'b1;
            rpcv_pkg::MV_DEC: ny = py_reg - 1'b1;
            default:          ny = py_reg;
        endcase
    end

    assign raddr = (ctrl.op == rpcv_pkg::OP_CHECK) ? rpcv_pkg::store_addr(ox_reg, oy_reg)
                                                  : rpcv_pkg::store_addr(nx, ny);

    rpcv_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rpcv_pkg::store_addr(in_ch.coord_x, in_ch.coord_y)),
        .wdata (rpcv_pkg::pix_class(in_ch.pixel_value)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = (ctrl.op == rpcv_pkg::OP_EMIT_VOTE) || (ctrl.op == rpcv_pkg::OP_EMIT_BAD)
                      || (ctrl.op == rpcv_pkg::OP_EMIT_IN);

    always_comb
    begin
        stat.query    = accept && in_ch.action;
        stat.bad      = ({1'b0, ox_reg} >= sx) || ({1'b0, oy_reg} >= sy);
        stat.full     = (rdata == rpcv_pkg::CLS_FULL);
        stat.at_edge  = edge_x || edge_y;
        stat.last_dir = (dir_reg == rpcv_pkg::DIR_LAST);
        stat.out_busy = !out_free;
    end

    always_comb
    begin
        size_x_next    = size_x_reg;
        size_y_next    = size_y_reg;
        out_valid_next = out_valid_reg;
        inside_next    = inside_reg;
        bad_next       = bad_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ocls_next      = ocls_reg;
        prev_next      = prev_reg;
        par_next       = par_reg;
        dir_next       = dir_reg;
        odd_next       = odd_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rpcv_pkg::REG_SIZE_X: size_x_next = cfg_data;
                rpcv_pkg::REG_SIZE_Y: size_y_next = cfg_data;
                default:              size_x_next = size_x_reg;
            endcase
        end

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            rpcv_pkg::OP_IDLE:
            begin
                if (accept)
                begin
                    ox_next = in_ch.coord_x;
                    oy_next = in_ch.coord_y;
                end
            end
            rpcv_pkg::OP_CHECK:
            begin
                ox_next = ox_reg;
            end
            rpcv_pkg::OP_CENTER:
            begin
                ocls_next = rdata;
                odd_next  = '0;
                dir_next  = '0;
            end
            rpcv_pkg::OP_RAY_INIT:
            begin
                px_next   = ox_reg;
                py_next   = oy_reg;
                prev_next = ocls_reg;
                par_next  = 1'b0;
            end
            rpcv_pkg::OP_STEP:
            begin
                if (!(edge_x || edge_y))
                begin
                    px_next = nx;
                    py_next = ny;
                end
            end
            rpcv_pkg::OP_CMP:
            begin
                if ((prev_reg == rpcv_pkg::CLS_ZERO) && (rdata == rpcv_pkg::CLS_FULL))
                begin
                    par_next = !par_reg;
                end
                prev_next = rdata;
            end
            rpcv_pkg::OP_RAY_END:
            begin
                odd_next = odd_reg + rpcv_pkg::ODD_W'(par_reg);
                dir_next = dir_reg + 1'b1;
            end
            default:
            begin
                // result steps, handled below
            end
        endcase

        if (emit && out_free)
        begin
            out_valid_next = 1'b1;
            inside_next    = (ctrl.op == rpcv_pkg::OP_EMIT_IN)
                             || ((ctrl.op == rpcv_pkg::OP_EMIT_VOTE)
                                 && (odd_reg >= rpcv_pkg::VOTE_MIN));
            bad_next       = (ctrl.op == rpcv_pkg::OP_EMIT_BAD);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= rpcv_pkg::SIZE_RESET;
            size_y_reg    <= rpcv_pkg::SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_x_reg    <= size_x_next;
            size_y_reg    <= size_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        bad_reg    <= bad_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ocls_reg   <= ocls_next;
        prev_reg   <= prev_next;
        par_reg    <= par_next;
        dir_reg    <= dir_next;
        odd_reg    <= odd_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.inside_res = inside_reg;
    assign out_ch.bad_point  = bad_reg;

endmodule
`default_nettype wire

// ===== tb/sv/contour_tb_pkg.sv =====
package contour_tb_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Sizes above the store act as the store size.
    function automatic int clip_size(input int s);
        int r;
        r = (s > rpcv_pkg::MAX_DIM) ? rpcv_pkg::MAX_DIM : s;
        return r;
    endfunction

    // Rays 0..7: +x, -x, +y, -y, then the diagonals (+,+), (+,-), (-,+), (-,-).
    function automatic int ray_dx(input int d);
        int v;
        case (d)
            0, 4, 5: v = 1;
            1, 6, 7: v = -1;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic int ray_dy(input int d);
        int v;
        case (d)
            2, 4, 6: v = 1;
            3, 5, 7: v = -1;
            default: v = 0;
        endcase
        return v;
    endfunction

    // True when the next step along the ray would leave the ex by ey image.
    function automatic bit ray_done(input int px, input int py, input int dx, input int dy,
                                    input int ex, input int ey);
        bit r;
        r = (dx > 0 && px + 1 >= ex) || (dx < 0 && px == 0) ||
            (dy > 0 && py + 1 >= ey) || (dy < 0 && py == 0);
        return r;
    endfunction

endpackage

// ===== tb/sv/contour_vote_checker.sv =====
module contour_vote_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpcv_pkg::SIZE_W-1:0]    cfg_data,
    rpcv_in_if                             in_ch,
    rpcv_out_if                            out_ch,
    output int                             errors,
    output int                             pending
);
    import rpcv_pkg::*;
    import contour_tb_pkg::*;

    typedef struct packed {
        logic in_shape;
        logic bad;
    } verdict_t;

    logic [CLS_W-1:0]  pix_cls [STORE_DEPTH];
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    verdict_t          verdict_q [$];

    function automatic logic [CLS_W-1:0] class_of(input logic [PIX_W-1:0] v);
        logic [CLS_W-1:0] c;
        if (v == '0)
            c = CLS_ZERO;
        else if (v == '1)
            c = CLS_FULL;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    function automatic logic [CLS_W-1:0] cls_at(input int px, input int py);
        return pix_cls[px * MAX_DIM + py];
    endfunction

    // Parity of zero-to-full steps from (qx, qy) along ray d.
    function automatic logic ray_odd(input int qx, input int qy, input int d,
                                     input int ex, input int ey);
        int   px;
        int   py;
        int   dx;
        int   dy;
        logic par;
        px  = qx;
        py  = qy;
        dx  = ray_dx(d);
        dy  = ray_dy(d);
        par = 1'b0;
        while (!ray_done(px, py, dx, dy, ex, ey))
        begin
            if (cls_at(px, py) == CLS_ZERO && cls_at(px + dx, py + dy) == CLS_FULL)
                par = ~par;
            px += dx;
            py += dy;
        end
        return par;
    endfunction

    function automatic verdict_t vote_point(input int qx, input int qy);
        verdict_t v;
        int       ex;
        int       ey;
        int       odd;
        ex         = clip_size(int'(size_x));
        ey         = clip_size(int'(size_y));
        v.in_shape = 1'b0;
        v.bad      = 1'b0;
        odd        = 0;
        if (qx >= ex || qy >= ey)
            v.bad = 1'b1;
        else if (cls_at(qx, qy) == CLS_FULL)
            v.in_shape = 1'b1;
        else
        begin
            for (int d = 0; d < 8; d++)
                odd += int'(ray_odd(qx, qy, d, ex, ey));
            v.in_shape = (odd >= 4);
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t got;
        verdict_t want;
        int       miss;
        miss = 0;
        if (!rst_n)
        begin
            size_x = SIZE_RESET;
            size_y = SIZE_RESET;
            verdict_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SIZE_X)
                    size_x = cfg_data;
                else if (cfg_index == REG_SIZE_Y)
                    size_y = cfg_data;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.in_shape = out_ch.inside_res;
                got.bad      = out_ch.bad_point;
                if (verdict_q.size() == 0)
                begin
                    $error("unrequested result: inside_res %0b bad_point %0b",
                           got.in_shape, got.bad);
                    miss++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.in_shape !== want.in_shape)
                    begin
                        $error("inside_res: expected %0b, got %0b",
                               want.in_shape, got.in_shape);
                        miss++;
                    end
                    if (got.bad !== want.bad)
                    begin
                        $error("bad_point: expected %0b, got %0b", want.bad, got.bad);
                        miss++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.action == ACT_WRITE)
                    pix_cls[int'(in_ch.coord_x) * MAX_DIM + int'(in_ch.coord_y)] =
                        class_of(in_ch.pixel_value);
                else
                    verdict_q.insert(verdict_q.size(),
                                     vote_point(int'(in_ch.coord_x), int'(in_ch.coord_y)));
            end
            errors  <= errors + miss;
            pending <= verdict_q.size();
        end
    end

endmodule

// ===== tb/sv/raster_point_in_contour_vote_core_tb.sv =====
module raster_point_in_contour_vote_core_tb;
    import rpcv_pkg::*;
    import contour_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 32;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    int chk_errors;
    int chk_pending;
    int cycles = 0;
    int rx_hold;
    int reqs_sent;
    int cur_sx;
    int cur_sy;
    bit quiet;
    bit fill_zero;
    bit painted [STORE_DEPTH];

    rpcv_in_if  in_ch ();
    rpcv_out_if out_ch ();

    raster_point_in_contour_vote_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    contour_vote_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (chk_errors),
        .pending   (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // After each accepted result, hold ready low for a drawn number of cycles with a result waiting.
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int n;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_hold      <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            n = quiet ? 0 : $urandom_range(0, 3);
            rx_hold      <= n;
            out_ch.ready <= (n == 0);
        end
        else if (rx_hold != 0)
        begin
            if (out_ch.valid)
            begin
                rx_hold      <= rx_hold - 1;
                out_ch.ready <= (rx_hold == 1);
            end
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("raster_point_in_contour_vote_core verification failed");
            $finish;
        end
    end

    function automatic int random_pixel();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
            v = 0;
        else if (r < 7)
            v = 255;
        else if (r < 9)
            v = $urandom_range(1, 254);
        else
            v = $urandom_range(0, 255);
        return v;
    endfunction

    function automatic int fill_value();
        int v;
        v = fill_zero ? 0 : random_pixel();
        return v;
    endfunction

    // One of 0, e-1, e, kept within the coordinate range.
    function automatic int edge_coord(input int e);
        int r;
        int v;
        r = $urandom_range(0, 2);
        v = (r == 0) ? 0 : ((r == 1) ? e - 1 : e);
        if (v < 0)
            v = 0;
        if (v > MAX_DIM - 1)
            v = MAX_DIM - 1;
        return v;
    endfunction

    // Leave valid high after acceptance; the next request or a wait lowers it.
    task automatic send_req(input logic act, input int x, input int y, input int pv);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.coord_x     <= COORD_W'(x);
        in_ch.coord_y     <= COORD_W'(y);
        in_ch.pixel_value <= PIX_W'(pv);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (act == ACT_WRITE)
            painted[x * MAX_DIM + y] = 1'b1;
        reqs_sent++;
    endtask

    task automatic drain(input bit settle);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int sx, input int sy);
        drain(1'b1);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIZE_X;
        cfg_data  <= SIZE_W'(sx);
        @(posedge clk);
        cfg_index <= REG_SIZE_Y;
        cfg_data  <= SIZE_W'(sy);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sx = sx;
        cur_sy = sy;
    endtask

    // Write every pixel that a query at (qx, qy) will read and that is still unset.
    task automatic prime_rays(input int qx, input int qy, input int ex, input int ey);
        int px;
        int py;
        int dx;
        int dy;
        for (int d = 0; d < 8; d++)
        begin
            px = qx;
            py = qy;
            dx = ray_dx(d);
            dy = ray_dy(d);
            if (!painted[px * MAX_DIM + py])
                send_req(ACT_WRITE, px, py, fill_value());
            while (!ray_done(px, py, dx, dy, ex, ey))
            begin
                px += dx;
                py += dy;
                if (!painted[px * MAX_DIM + py])
                    send_req(ACT_WRITE, px, py, fill_value());
            end
        end
    endtask

    task automatic ask_point(input int x, input int y);
        int ex;
        int ey;
        ex = clip_size(cur_sx);
        ey = clip_size(cur_sy);
        if (x < ex && y < ey)
            prime_rays(x, y, ex, ey);
        send_req(ACT_QUERY, x, y, $urandom_range(0, 255));
    endtask

    task automatic draw_box(input int x0, input int y0, input int w, input int h, input int v);
        for (int x = x0; x < x0 + w; x++)
        begin
            send_req(ACT_WRITE, x, y0, v);
            if (h > 1)
                send_req(ACT_WRITE, x, y0 + h - 1, v);
        end
        for (int y = y0 + 1; y < y0 + h - 1; y++)
        begin
            send_req(ACT_WRITE, x0, y, v);
            if (w > 1)
                send_req(ACT_WRITE, x0 + w - 1, y, v);
        end
    endtask

    task automatic pick_spot(input int ex, input int ey, output int x, output int y);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 || ex == 0 || ey == 0)
        begin
            x = $urandom_range(0, MAX_DIM - 1);
            y = $urandom_range(0, MAX_DIM - 1);
        end
        else if (r < 30)
        begin
            x = edge_coord(ex);
            y = edge_coord(ey);
        end
        else
        begin
            x = $urandom_range(0, ex - 1);
            y = $urandom_range(0, ey - 1);
        end
    endtask

    task automatic run_phase(input int sx, input int sy, input int n, input bit calm);
        int ex;
        int ey;
        int r;
        int bw;
        int bh;
        int x;
        int y;
        int stop;
        set_size(sx, sy);
        quiet     = calm;
        fill_zero = 1'b0;
        ex        = clip_size(sx);
        ey        = clip_size(sy);
        stop      = reqs_sent + n;
        while (reqs_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 8 && ex > 0 && ey > 0)
            begin
                bw = $urandom_range(1, (ex < 20) ? ex : 20);
                bh = $urandom_range(1, (ey < 20) ? ey : 20);
                draw_box($urandom_range(0, ex - bw), $urandom_range(0, ey - bh), bw, bh,
                         ($urandom_range(0, 9) == 0) ? 0 : 255);
            end
            else if (r < 45)
            begin
                pick_spot(ex, ey, x, y);
                send_req(ACT_WRITE, x, y, random_pixel());
            end
            else if (r < 47)
                drain(1'b0);
            else
            begin
                pick_spot(ex, ey, x, y);
                ask_point(x, y);
            end
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_SIZE_X;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_WRITE;
        in_ch.coord_x     <= '0;
        in_ch.coord_y     <= '0;
        in_ch.pixel_value <= '0;
        quiet     = 1'b0;
        fill_zero = 1'b1;
        reqs_sent = 0;
        cur_sx    = int'(SIZE_RESET);
        cur_sy    = int'(SIZE_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: a full center answers without walking any ray.
        send_req(ACT_WRITE, 100, 100, 255);
        send_req(ACT_QUERY, 100, 100, 0);
        send_req(ACT_WRITE, 511, 511, 255);
        send_req(ACT_QUERY, 511, 511, 0);

        // Zero background: other center, a closed outline around the point, and
        // the corners.
        set_size(12, 12);
        send_req(ACT_WRITE, 5, 5, 7);
        ask_point(5, 5);
        draw_box(2, 2, 8, 8, 255);
        ask_point(4, 4);
        ask_point(0, 0);
        ask_point(11, 11);
        ask_point(11, 0);

        // Small image: last good pixel, bad points just past each edge.
        set_size(6, 5);
        fill_zero = 1'b0;
        ask_point(5, 4);
        ask_point(6, 0);
        ask_point(0, 5);
        send_req(ACT_WRITE, 511, 511, 254);
        ask_point(511, 511);
        ask_point(0, 0);

        // Zero extent: every point is bad.
        set_size(0, 5);
        ask_point(0, 0);

        run_phase(0, 5, 15, 1'b0);
        run_phase(1, 1, 25, 1'b0);
        run_phase(16, 16, 170, 1'b0);
        run_phase(8, 24, 90, 1'b1);
        run_phase(1023, 1, 560, 1'b0);
        run_phase(2, 2, 30, 1'b0);
        run_phase(32, 5, 80, 1'b0);
        run_phase(7, 0, 10, 1'b0);

        drain(1'b1);
        if (chk_errors == 0)
            $display("raster_point_in_contour_vote_core verification clean");
        else
            $display("raster_point_in_contour_vote_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rpcv_pkg.sv
src/rpcv_in_if.sv
src/rpcv_out_if.sv
src/rpcv_ram.sv
src/rpcv_seq.sv
src/rpcv_dp.sv
src/raster_point_in_contour_vote_core.sv
tb/sv/contour_tb_pkg.sv
tb/sv/contour_vote_checker.sv
tb/sv/raster_point_in_contour_vote_core_tb.sv
